// ===== hdl/ftc_pkg.sv =====
// Package for the finite-time consensus follower: fixed-point widths
// and CSR index constants. No dependencies.
`timescale 1ns / 1ps
package ftc_pkg;
   localparam int FracBits = 24;
   localparam int WordBits = 32;
   localparam int CsrIdxBits = 3;
   localparam int CsrDataBits = 32;
   localparam logic [CsrIdxBits-1:0] CSR_GAIN_VEL = 3'd0;
   localparam logic [CsrIdxBits-1:0] CSR_GAIN_POS = 3'd1;
   localparam logic [CsrIdxBits-1:0] CSR_OFF_X    = 3'd2;
   localparam logic [CsrIdxBits-1:0] CSR_OFF_Y    = 3'd3;
   localparam logic [CsrIdxBits-1:0] CSR_OFF_Z    = 3'd4;
   localparam logic [CsrIdxBits-1:0] CSR_DT       = 3'd5;
   localparam logic [CsrIdxBits-1:0] CSR_LIMIT    = 3'd6;
endpackage

// ===== hdl/ftc_mul.sv =====
// Shared signed fixed-point multiplier, one product per cycle, registered,
// round half away from zero and saturate. Uses ftc_pkg.
`timescale 1ns / 1ps
module ftc_mul #(
   parameter int FRAC_BITS = ftc_pkg::FracBits,
   parameter int WORD_BITS = ftc_pkg::WordBits
) (
   input  logic                        clock,
   input  logic signed [WORD_BITS-1:0] a,
   input  logic signed [WORD_BITS-1:0] b,
   output logic signed [WORD_BITS-1:0] p
);
   localparam int PW = 2 * WORD_BITS;
   logic [WORD_BITS-1:0] ma, mb;
   logic [PW:0] prod, rnd;
   logic [PW:0] q;
   logic neg;
   logic signed [WORD_BITS-1:0] p_in;
   logic signed [WORD_BITS-1:0] p_ff;
   localparam logic [WORD_BITS-1:0] MaxMag = {1'b0, {(WORD_BITS-1){1'b1}}};
   always_comb begin
      ma = a[WORD_BITS-1] ? WORD_BITS'(-a) : WORD_BITS'(a);
      mb = b[WORD_BITS-1] ? WORD_BITS'(-b) : WORD_BITS'(b);
      neg = a[WORD_BITS-1] ^ b[WORD_BITS-1];
      prod = (PW+1)'(ma) * (PW+1)'(mb);
      rnd = prod + ((PW+1)'(1) << (FRAC_BITS - 1));
      q = rnd >> FRAC_BITS;
      if (neg) begin
         if (q > (PW+1)'(MaxMag) + 1) p_in = {1'b1, {(WORD_BITS-1){1'b0}}};
         else p_in = WORD_BITS'(-q);
      end else begin
         if (q > (PW+1)'(MaxMag)) p_in = MaxMag;
         else p_in = WORD_BITS'(q);
      end
   end
   always_ff @(posedge clock) p_ff <= p_in;
   assign p = p_ff;
endmodule

// ===== hdl/ftc_cbrt.sv =====
// Iterative integer cube root for Q-format magnitudes: one result bit per
// pass through SQ, CL and CU on one shared RB x RB multiplier. Uses ftc_pkg.
`timescale 1ns / 1ps
module ftc_cbrt #(
   parameter int FRAC_BITS = ftc_pkg::FracBits,
   parameter int WORD_BITS = ftc_pkg::WordBits
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [WORD_BITS-1:0] e,
   output logic                        done,
   output logic signed [WORD_BITS-1:0] r
);
   // radicand = |e| << 2F; root up to (W + 2F + 2)/3 + 1 bits
   localparam int NW = WORD_BITS + 2 * FRAC_BITS;
   localparam int RB = (NW + 2) / 3 + 1;
   localparam int BW = $clog2(RB + 1);
   typedef enum logic [2:0] {IDLE, SQ, CL, CU, FIN} st_type;
   st_type st_ff;
   logic [BW-1:0] bit_ff;
   logic [RB-1:0] root_ff, cand, mul_a;
   logic [2*RB-1:0] sq_ff, pl_ff, prod;
   logic [3*RB-1:0] cube;
   logic [NW-1:0] n_ff;
   logic neg_ff;
   logic [WORD_BITS-1:0] mag;
   logic signed [WORD_BITS-1:0] r_ff;
   logic done_ff;
   localparam logic [RB-1:0] MaxMag = RB'({(WORD_BITS-1){1'b1}});
   // cand^3 = cand * cand, then low and high halves of square times cand
   always_comb begin
      mag = e[WORD_BITS-1] ? WORD_BITS'(-e) : WORD_BITS'(e);
      cand = root_ff | (RB'(1) << bit_ff);
      mul_a = (st_ff == SQ) ? cand : (st_ff == CL) ? sq_ff[RB-1:0] : sq_ff[2*RB-1:RB];
      prod = (2*RB)'(mul_a) * (2*RB)'(cand);
      cube = ((3*RB)'(prod) << RB) + (3*RB)'(pl_ff);
   end
   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         st_ff <= IDLE;
      end else begin
         unique case (st_ff)
            IDLE: if (start) begin
               n_ff <= NW'(mag) << (2 * FRAC_BITS);
               neg_ff <= e[WORD_BITS-1];
               root_ff <= '0;
               bit_ff <= BW'(RB - 1);
               st_ff <= SQ;
            end
            SQ: begin
               sq_ff <= prod;
               st_ff <= CL;
            end
            CL: begin
               pl_ff <= prod;
               st_ff <= CU;
            end
            CU: begin
               if (cube <= (3*RB)'(n_ff)) root_ff <= cand;
               if (bit_ff == '0) st_ff <= FIN;
               else begin
                  bit_ff <= bit_ff - 1'b1;
                  st_ff <= SQ;
               end
            end
            FIN: begin
               if (neg_ff)
                  r_ff <= (root_ff > MaxMag) ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                             : -WORD_BITS'(root_ff);
               else
                  r_ff <= (root_ff > MaxMag) ? WORD_BITS'(MaxMag) : WORD_BITS'(root_ff);
               done_ff <= 1'b1;
               st_ff <= IDLE;
            end
            default: st_ff <= IDLE;
         endcase
      end
   end
   assign done = done_ff;
   assign r = r_ff;
endmodule

// ===== hdl/finite_time_consensus_follower.sv =====
// Top level of the finite-time consensus follower: sequencer, state,
// registers. Depends on ftc_pkg, ftc_mul and ftc_cbrt.
//
// One req item is one control tick (req_tdata bit 0: step_enable). One rsp
// item follows per tick: rsp_tdata holds setpoint_y, setpoint_x, setpoint_z
// from bit 0 up; rsp_tuser = finished. With step_enable low the sequencer
// goes from S_IDLE straight to S_OUT; with it high it runs S_LA, S_LAW, S_LV,
// S_LVW and S_LP per leader axis, then per follower axis two cube roots plus
// the multiply and update states, then S_OUT. The cube root unit runs its
// SQ, CL and CU states for each root bit, 28 bits at Q7.24. The next item is
// taken only after the result has been accepted. req_tready is low while a
// tick is in work or its result waits; a stalled rsp holds its payload. Reset
// (synchronous) restores the csr registers, sequencer and axis state; the csr
// port writes one register per cycle. The user writes it only while idle;
// the block itself does not enforce this.
`timescale 1ns / 1ps
module finite_time_consensus_follower #(
   parameter int FRAC_BITS = ftc_pkg::FracBits,
   parameter int WORD_BITS = ftc_pkg::WordBits
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // step_enable
   input  logic                                csr_wen,
   input  logic [ftc_pkg::CsrIdxBits-1:0]      csr_idx,
   input  logic [ftc_pkg::CsrDataBits-1:0]     csr_wdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((3*WORD_BITS+7)/8)*8-1:0]    rsp_tdata,  // setpoint_y, setpoint_x, setpoint_z from bit 0 up
   output logic                                rsp_tuser   // finished
);
   import ftc_pkg::*;
   localparam int W = WORD_BITS;
   localparam int DW = ((3*W+7)/8)*8;
   typedef logic signed [W-1:0] w_type;
   localparam logic signed [W:0] WMax = (W+1)'({1'b0, {(W-1){1'b1}}});
   localparam logic signed [W:0] WMin = -WMax - 1;

   function automatic w_type qpct(input int pct);
      longint m;
      m = ((longint'(pct < 0 ? -pct : pct) << FRAC_BITS) + 50) / 100;
      return pct < 0 ? w_type'(-m) : w_type'(m);
   endfunction
   function automatic w_type sat(input logic signed [W:0] v);
      if (v > WMax) return w_type'(WMax);
      if (v < WMin) return w_type'(WMin);
      return w_type'(v);
   endfunction
   function automatic w_type sadd(input w_type a, input w_type b);
      return sat((W+1)'(a) + (W+1)'(b));
   endfunction
   function automatic w_type ssub(input w_type a, input w_type b);
      return sat((W+1)'(a) - (W+1)'(b));
   endfunction
   function automatic w_type satu(input logic [31:0] v);
      if (33'(v) > 33'(WMax)) return w_type'(WMax);
      return w_type'(v);
   endfunction
   function automatic w_type sats(input logic signed [31:0] v);
      if (64'(v) > 64'(WMax)) return w_type'(WMax);
      if (64'(v) < 64'(WMin)) return w_type'(WMin);
      return w_type'(v);
   endfunction
   // follower position limits; beyond a limit the axis snaps to its inner value
   function automatic w_type clamp_pos(input w_type v, input logic [1:0] ax);
      if (ax == 2'd0) begin
         if (v > qpct(85)) return qpct(80);
         if (v < qpct(-85)) return qpct(-80);
      end else if (ax == 2'd1) begin
         if (v > qpct(110)) return qpct(100);
         if (v < qpct(-110)) return qpct(-100);
      end else begin
         if (v > qpct(65)) return qpct(60);
      end
      return v;
   endfunction

   // registers
   logic [30:0] gv_ff, gp_ff;
   logic signed [31:0] off_ff [3];
   logic [24:0] dt_ff;
   logic [15:0] lim_ff, tick_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         gv_ff <= 31'd23488102; gp_ff <= 31'd10066330;
         off_ff[0] <= '0; off_ff[1] <= 32'sd5804917; off_ff[2] <= '0;
         dt_ff <= 25'd167772; lim_ff <= 16'd1500;
      end else if (csr_wen) begin
         unique case (csr_idx)
            CSR_GAIN_VEL: gv_ff <= csr_wdata[30:0];
            CSR_GAIN_POS: gp_ff <= csr_wdata[30:0];
            CSR_OFF_X:    off_ff[0] <= csr_wdata;
            CSR_OFF_Y:    off_ff[1] <= csr_wdata;
            CSR_OFF_Z:    off_ff[2] <= csr_wdata;
            CSR_DT:       dt_ff <= csr_wdata[24:0];
            CSR_LIMIT:    lim_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // shared units
   w_type ma, mb, mp, ce, cr;
   logic cstart, cdone;
   ftc_mul #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(W)) u_mul (
      .clock(clock), .a(ma), .b(mb), .p(mp));
   ftc_cbrt #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(W)) u_cbrt (
      .clock(clock), .reset(reset), .start(cstart), .e(ce), .done(cdone), .r(cr));

   typedef enum logic [4:0] {
      S_IDLE, S_LA, S_LAW, S_LV, S_LVW, S_LP, S_CEV, S_CEVW, S_UW, S_U, S_FVW,
      S_FV, S_CEPW, S_GPW, S_GP, S_FPW, S_FP, S_OUT
   } st_type;
   st_type st_ff;
   logic [1:0] ax_ff;
   logic fin_ff;
   w_type lp_ff [3], lv_ff [3], fp_ff [3], fv_ff [3];
   w_type t_ff, s_ff;
   w_type dt, gv, gp, tgt, fpc;
   logic [1:0] ph;
   logic rv_ff;

   always_comb begin
      dt = satu(32'(dt_ff));
      gv = satu(32'(gv_ff));
      gp = satu(32'(gp_ff));
      ph = (tick_ff < 16'd299) ? 2'd0 : (tick_ff < 16'd599) ? 2'd1 :
           (tick_ff < 16'd899) ? 2'd2 : 2'd3;
      unique case ({ph, ax_ff})
         4'b0000: tgt = qpct(6);   4'b0001: tgt = qpct(-20); 4'b0010: tgt = qpct(8);
         4'b0100: tgt = qpct(0);   4'b0101: tgt = qpct(-20); 4'b0110: tgt = qpct(0);
         4'b1000: tgt = qpct(-12); 4'b1001: tgt = qpct(0);   4'b1010: tgt = qpct(8);
         4'b1100: tgt = qpct(0);   4'b1101: tgt = qpct(13);  4'b1110: tgt = qpct(0);
         default: tgt = '0;
      endcase
      // multiplier operands are registered (t_ff, s_ff); ftc_mul registers the product again
      ma = t_ff; mb = s_ff;
      // velocity error root starts in S_CEV, position error root in S_FV
      cstart = (st_ff == S_CEV) || (st_ff == S_FV);
      ce = (st_ff == S_CEV) ? ssub(lv_ff[ax_ff], fv_ff[ax_ff])
           : ssub(ssub(fp_ff[ax_ff], lp_ff[ax_ff]), sats(off_ff[ax_ff]));
      fpc = clamp_pos(sadd(fp_ff[ax_ff], mp), ax_ff);
   end

   // sequencer: with step_enable, leader axes, then follower axes with clamp, then output; else output only
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; rv_ff <= 1'b0; tick_ff <= '0; ax_ff <= '0;
         lp_ff[0] <= qpct(0); lp_ff[1] <= qpct(60); lp_ff[2] <= qpct(11);
         fp_ff[0] <= qpct(80); fp_ff[1] <= qpct(100); fp_ff[2] <= qpct(11);
         for (int k = 0; k < 3; k++) begin lv_ff[k] <= '0; fv_ff[k] <= '0; end
      end else begin
         if (rv_ff && rsp_tready) rv_ff <= 1'b0;
         unique case (st_ff)
            S_IDLE: if (req_tvalid && req_tready) begin
               fin_ff <= tick_ff >= lim_ff;
               ax_ff <= '0;
               st_ff <= req_tdata[0] ? S_LA : S_OUT;
            end
            S_LA:  begin t_ff <= ssub(tgt, lv_ff[ax_ff]); s_ff <= dt; st_ff <= S_LAW; end
            S_LAW: st_ff <= S_LV;
            S_LV:  begin
               t_ff <= sadd(lv_ff[ax_ff], mp);
               lv_ff[ax_ff] <= sadd(lv_ff[ax_ff], mp);
               st_ff <= S_LVW;
            end
            S_LVW: st_ff <= S_LP;
            S_LP:  begin
               lp_ff[ax_ff] <= sadd(lp_ff[ax_ff], mp);
               if (ax_ff == 2'd2) begin ax_ff <= '0; st_ff <= S_CEV; end
               else begin ax_ff <= ax_ff + 1'b1; st_ff <= S_LA; end
            end
            S_CEV:  st_ff <= S_CEVW;
            S_CEVW: if (cdone) begin t_ff <= gv; s_ff <= cr; st_ff <= S_UW; end
            S_UW:  st_ff <= S_U;
            S_U:   begin t_ff <= mp; s_ff <= dt; st_ff <= S_FVW; end
            S_FVW: st_ff <= S_FV;
            S_FV:  begin fv_ff[ax_ff] <= sadd(fv_ff[ax_ff], mp); st_ff <= S_CEPW; end
            S_CEPW: if (cdone) begin t_ff <= gp; s_ff <= cr; st_ff <= S_GPW; end
            S_GPW: st_ff <= S_GP;
            S_GP:  begin t_ff <= ssub(fv_ff[ax_ff], mp); s_ff <= dt; st_ff <= S_FPW; end
            S_FPW: st_ff <= S_FP;
            S_FP:  begin
               fp_ff[ax_ff] <= fpc;
               if (ax_ff == 2'd2) st_ff <= S_OUT;
               else begin ax_ff <= ax_ff + 1'b1; st_ff <= S_CEV; end
            end
            S_OUT: begin
               if (!fin_ff) tick_ff <= tick_ff + 1'b1;
               rv_ff <= 1'b1;
               st_ff <= S_IDLE;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end
   assign req_tready = (st_ff == S_IDLE) && !rv_ff;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = DW'({fp_ff[2], fp_ff[0], fp_ff[1]});
   assign rsp_tuser = fin_ff;

`ifndef ASSERT_OFF
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser));
   a_no_req_with_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready);
   a_cbrt_done: assert property (@(posedge clock) disable iff (reset)
      cdone |-> (st_ff == S_CEVW) || (st_ff == S_CEPW));
`endif
endmodule
